@@ design/sscs_pkg.sv @@
// Shared types, constants and the commutation step table for the six-step sequencer.
package sscs_pkg;

   localparam int PHASES   = 3;
   localparam int MAX_CMDS = 4;
   localparam int CNT_W    = 3;
   localparam int DUTY_W   = 14;
   localparam int FREQ_W   = 32;
   localparam int STEP_W   = 3;
   localparam int CSR_W    = 2;

   localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

   // Reset values of the duty registers, 0.01 % units
   localparam logic [DUTY_W-1:0] FLOOR_RESET   = 14'd200;
   localparam logic [DUTY_W-1:0] CEILING_RESET = 14'd9800;
   localparam logic [DUTY_W-1:0] IDLE_RESET    = 14'd0;

   typedef enum logic [1:0] {
      OP_STEP     = 2'd0,
      OP_SET_DUTY = 2'd1,
      OP_STOP     = 2'd2,
      OP_INIT     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_SET_FREQ = 2'd0,
      CMD_SET_MODE = 2'd1,
      CMD_SET_DUTY = 2'd2
   } kind_type;

   // DRV_UNKNOWN only lives in the mode cache
   typedef enum logic [1:0] {
      DRV_OFF     = 2'd0,
      DRV_HIGH    = 2'd1,
      DRV_LOW     = 2'd2,
      DRV_UNKNOWN = 2'd3
   } drive_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_FLOOR   = 2'd0,
      CSR_CEILING = 2'd1,
      CSR_IDLE    = 2'd2
   } csr_type;

   typedef struct packed {
      op_type              mode;
      logic [STEP_W-1:0]   step_index;
      logic [FREQ_W-1:0]   pwm_frequency;
      logic [DUTY_W-1:0]   duty_request;
   } item_type;

   typedef struct packed {
      logic [DUTY_W-1:0] floor;
      logic [DUTY_W-1:0] ceiling;
      logic [DUTY_W-1:0] idle;
   } cfg_type;

   typedef struct packed {
      logic [FREQ_W-1:0]               prev_freq;
      drive_type [PHASES-1:0]          mode;
      logic [PHASES-1:0][DUTY_W-1:0]   duty;
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [1:0]          phase;
      drive_type           drive;
      logic [DUTY_W-1:0]   duty;
      logic [FREQ_W-1:0]   freq;
      logic                last;
   } cmd_type;

   // Drive of one phase in one commutation step (U, V, W)
   function automatic drive_type step_drive(input logic [STEP_W-1:0] step,
                                            input logic [1:0] ph);
      drive_type u, v, w;
      unique case (step)
         3'd0:    begin u = DRV_HIGH; v = DRV_LOW;  w = DRV_OFF;  end
         3'd1:    begin u = DRV_HIGH; v = DRV_OFF;  w = DRV_LOW;  end
         3'd2:    begin u = DRV_OFF;  v = DRV_HIGH; w = DRV_LOW;  end
         3'd3:    begin u = DRV_LOW;  v = DRV_HIGH; w = DRV_OFF;  end
         3'd4:    begin u = DRV_LOW;  v = DRV_OFF;  w = DRV_HIGH; end
         3'd5:    begin u = DRV_OFF;  v = DRV_LOW;  w = DRV_HIGH; end
         default: begin u = DRV_OFF;  v = DRV_OFF;  w = DRV_OFF;  end
      endcase
      unique case (ph)
         2'd0:    return u;
         2'd1:    return v;
         default: return w;
      endcase
   endfunction

endpackage

@@ design/sscs_channels.sv @@
// Handshake channel interfaces for the sequencer's request and command streams.
interface sscs_req_if import sscs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [STEP_W-1:0]   step_index;
   logic [FREQ_W-1:0]   pwm_frequency;
   logic [DUTY_W-1:0]   duty_request;

   modport source (output valid, mode, step_index, pwm_frequency, duty_request,
                   input ready);
   modport sink   (input valid, mode, step_index, pwm_frequency, duty_request,
                   output ready);
endinterface

interface sscs_rsp_if import sscs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          command_kind;
   logic [1:0]          phase;
   logic [1:0]          drive_mode;
   logic [DUTY_W-1:0]   duty_value;
   logic [FREQ_W-1:0]   frequency_value;
   logic                last_command;

   modport source (output valid, command_kind, phase, drive_mode, duty_value,
                   frequency_value, last_command, input ready);
   modport sink   (input valid, command_kind, phase, drive_mode, duty_value,
                   frequency_value, last_command, output ready);
endinterface

@@ design/sscs_cmd_gen.sv @@
// Command generator: builds the packed command list and next cache state for one item.
module sscs_cmd_gen import sscs_pkg::*; (
   input  item_type                   item,
   input  cfg_type                    cfg,
   input  state_type                  st,
   output state_type                  nxt,
   output cmd_type [MAX_CMDS-1:0]     list,
   output logic [CNT_W-1:0]           count
);

   logic [DUTY_W-1:0] raised;
   logic [DUTY_W-1:0] sat;

   // Raise to floor first, then clip to ceiling
   assign raised = (item.duty_request < cfg.floor) ? cfg.floor : item.duty_request;
   assign sat    = (raised > cfg.ceiling) ? cfg.ceiling : raised;

   always_comb begin
      logic                  freq_change;
      logic                  step_ok;
      drive_type             m;
      drive_type             eff;
      logic [DUTY_W-1:0]     d;
      cmd_type [MAX_CMDS-1:0] cand;
      logic [MAX_CMDS-1:0]   emit;
      logic [CNT_W-1:0]      n;
      logic [CNT_W-1:0]      last_idx;

      nxt         = st;
      cand        = '0;
      emit        = '0;
      freq_change = (item.pwm_frequency != st.prev_freq);
      step_ok     = (item.step_index <= LAST_STEP);

      // Slot 0 is the frequency command, slots 1..3 are phases U, V, W
      unique case (item.mode)
         OP_STEP: begin
            if (step_ok) begin
               if (freq_change) begin
                  emit[0]       = 1'b1;
                  cand[0].kind  = CMD_SET_FREQ;
                  cand[0].drive = DRV_OFF;
                  cand[0].freq  = item.pwm_frequency;
                  nxt.prev_freq = item.pwm_frequency;
               end
               for (int ch = 0; ch < PHASES; ch++) begin
                  m   = step_drive(item.step_index, 2'(ch));
                  eff = freq_change ? DRV_UNKNOWN : st.mode[ch];
                  d   = (m == DRV_HIGH) ? sat : (m == DRV_LOW) ? cfg.floor : cfg.idle;
                  nxt.mode[ch] = eff;
                  cand[ch+1].phase = 2'(ch);
                  cand[ch+1].duty  = d;
                  if (m != eff) begin
                     emit[ch+1]       = 1'b1;
                     cand[ch+1].kind  = CMD_SET_MODE;
                     cand[ch+1].drive = m;
                     nxt.mode[ch]     = m;
                     nxt.duty[ch]     = d;
                  end else if (m == DRV_HIGH && d != st.duty[ch]) begin
                     emit[ch+1]       = 1'b1;
                     cand[ch+1].kind  = CMD_SET_DUTY;
                     cand[ch+1].drive = DRV_HIGH;
                     nxt.duty[ch]     = d;
                  end
               end
            end
         end
         OP_SET_DUTY: begin
            // exactly one high-side phase per valid step
            if (step_ok) begin
               for (int ch = 0; ch < PHASES; ch++) begin
                  if (step_drive(item.step_index, 2'(ch)) == DRV_HIGH) begin
                     emit[ch+1]       = 1'b1;
                     cand[ch+1].kind  = CMD_SET_DUTY;
                     cand[ch+1].phase = 2'(ch);
                     cand[ch+1].drive = DRV_HIGH;
                     cand[ch+1].duty  = sat;
                     nxt.duty[ch]     = sat;
                  end
               end
            end
         end
         default: begin
            // stop and init: all phases off; init also forgets the modes
            for (int ch = 0; ch < PHASES; ch++) begin
               emit[ch+1]       = 1'b1;
               cand[ch+1].kind  = CMD_SET_MODE;
               cand[ch+1].phase = 2'(ch);
               cand[ch+1].drive = DRV_OFF;
               cand[ch+1].duty  = cfg.idle;
               if (item.mode == OP_INIT) begin
                  nxt.mode[ch] = DRV_UNKNOWN;
               end
            end
         end
      endcase

      // Pack emitted candidates in order and flag the final one
      n    = '0;
      list = '0;
      for (int i = 0; i < MAX_CMDS; i++) begin
         if (emit[i]) begin
            list[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      last_idx = n - 3'd1;
      if (n != '0) begin
         list[last_idx[1:0]].last = 1'b1;
      end
      count = n;
   end

endmodule

@@ design/six_step_commutation_sequencer.sv @@
// Top level of the six-step commutation sequencer: input register, generator, command queue.
// An item is taken into an input register; from there it is turned into
// its whole list of timer commands (none to four), which is loaded into the queue together
// with the updated phase caches, and the commands then leave on rsp one per cycle, while
// rsp is ready, from a four-entry output register. The command output register sets the
// rate: an item that causes n commands occupies it until all n have left. The next item is
// taken into the input register as soon as the previous one has moved into the queue, and
// waits there until the queue's last command leaves. Configuration writes take effect on
// the next clock edge.
module six_step_commutation_sequencer import sscs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   sscs_req_if.sink            req,
   sscs_rsp_if.source          rsp,
   input  logic                csr_write_enable,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [DUTY_W-1:0]   csr_write_data
);

   logic                   in_valid_ff, in_valid_in;
   item_type               in_ff;
   cfg_type                cfg_ff, cfg_in;
   state_type              state_ff, state_in;
   cmd_type [MAX_CMDS-1:0] list_ff, list_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   state_type              gen_state;
   cmd_type [MAX_CMDS-1:0] gen_list;
   logic [CNT_W-1:0]       gen_cnt;

   logic req_take;
   logic rsp_pop;
   logic load;

   sscs_cmd_gen u_cmd_gen (
      .item  (in_ff),
      .cfg   (cfg_ff),
      .st    (state_ff),
      .nxt   (gen_state),
      .list  (gen_list),
      .count (gen_cnt)
   );

   // Handshake control
   assign rsp_pop   = rsp.valid && rsp.ready;
   assign load      = in_valid_ff &&
                      ((cnt_ff == '0) || ((cnt_ff == 3'd1) && rsp_pop));
   assign req.ready = !in_valid_ff || load;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // Command queue: load a fresh list or shift out the head
   always_comb begin
      list_in  = list_ff;
      cnt_in   = cnt_ff;
      state_in = state_ff;
      if (load) begin
         list_in  = gen_list;
         cnt_in   = gen_cnt;
         state_in = gen_state;
      end else if (rsp_pop) begin
         for (int i = 0; i < MAX_CMDS - 1; i++) begin
            list_in[i] = list_ff[i+1];
         end
         list_in[MAX_CMDS-1] = '0;
         cnt_in = cnt_ff - 3'd1;
      end
   end

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FLOOR:   cfg_in.floor   = csr_write_data;
            CSR_CEILING: cfg_in.ceiling = csr_write_data;
            CSR_IDLE:    cfg_in.idle    = csr_write_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // Control and cache state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         cnt_ff             <= '0;
         cfg_ff.floor       <= FLOOR_RESET;
         cfg_ff.ceiling     <= CEILING_RESET;
         cfg_ff.idle        <= IDLE_RESET;
         state_ff.prev_freq <= '0;
         for (int ph = 0; ph < PHASES; ph++) begin
            state_ff.mode[ph] <= DRV_UNKNOWN;
         end
         state_ff.duty      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.mode          <= op_type'(req.mode);
         in_ff.step_index    <= req.step_index;
         in_ff.pwm_frequency <= req.pwm_frequency;
         in_ff.duty_request  <= req.duty_request;
      end
      list_ff <= list_in;
   end

   // Head of the queue drives the result channel
   assign rsp.valid           = (cnt_ff != '0);
   assign rsp.command_kind    = list_ff[0].kind;
   assign rsp.phase           = list_ff[0].phase;
   assign rsp.drive_mode      = list_ff[0].drive;
   assign rsp.duty_value      = list_ff[0].duty;
   assign rsp.frequency_value = list_ff[0].freq;
   assign rsp.last_command    = list_ff[0].last;

`ifndef SYNTHESIS
   // The last flag marks the final queued command of an item
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (list_ff[0].last == (cnt_ff == 3'd1)))
      else $error("last flag out of step with queue count");

   // A frequency update always forces phase commands after it
   assert property (@(posedge clock) disable iff (reset)
      rsp_pop && list_ff[0].kind == CMD_SET_FREQ
      |=> rsp.valid && list_ff[0].kind == CMD_SET_MODE)
      else $error("frequency update not followed by phase mode set");

   // Queue never holds more than four commands
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MAX_CMDS))
      else $error("command queue overflow");

   // Input is only refused while an item waits in the input register
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && cnt_ff != '0)
      else $error("input stalled without a pending item");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the six-step commutation sequencer.
module testbench;
   import sscs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int SEGMENT_ITEMS = 37;

   // Predicts the timer commands of each accepted item and checks the command stream
   class commutation_scoreboard;
      logic [DUTY_W-1:0] duty_floor, duty_ceiling, duty_idle;
      logic [FREQ_W-1:0] freq_now;
      drive_type         mode_now [PHASES];
      logic [DUTY_W-1:0] duty_now [PHASES];
      cmd_type           expected [$];
      int                errors;

      function new();
         duty_floor   = FLOOR_RESET;
         duty_ceiling = CEILING_RESET;
         duty_idle    = IDLE_RESET;
         freq_now     = '0;
         errors       = 0;
         for (int ph = 0; ph < PHASES; ph++) begin
            mode_now[ph] = DRV_UNKNOWN;
            duty_now[ph] = '0;
         end
      endfunction

      function void write_reg(csr_type idx, logic [DUTY_W-1:0] value);
         case (idx)
            CSR_FLOOR:   duty_floor = value;
            CSR_CEILING: duty_ceiling = value;
            CSR_IDLE:    duty_idle = value;
            default: ;
         endcase
      endfunction

      // Raise to the floor first, then cap at the ceiling
      function logic [DUTY_W-1:0] clamp(logic [DUTY_W-1:0] d);
         logic [DUTY_W-1:0] r;
         r = d;
         if (r < duty_floor) r = duty_floor;
         if (r > duty_ceiling) r = duty_ceiling;
         return r;
      endfunction

      // Drive pattern per step, packed W, V, U from the top
      function drive_type planned_drive(logic [STEP_W-1:0] step, int ph);
         logic [5:0] wvu;
         case (step)
            3'd0:    wvu = {DRV_OFF,  DRV_LOW,  DRV_HIGH};
            3'd1:    wvu = {DRV_LOW,  DRV_OFF,  DRV_HIGH};
            3'd2:    wvu = {DRV_LOW,  DRV_HIGH, DRV_OFF};
            3'd3:    wvu = {DRV_OFF,  DRV_HIGH, DRV_LOW};
            3'd4:    wvu = {DRV_HIGH, DRV_OFF,  DRV_LOW};
            3'd5:    wvu = {DRV_HIGH, DRV_LOW,  DRV_OFF};
            default: wvu = {DRV_OFF,  DRV_OFF,  DRV_OFF};
         endcase
         return drive_type'(wvu[2*ph +: 2]);
      endfunction

      function void add(kind_type k, int ph, drive_type dv, logic [DUTY_W-1:0] du,
                        logic [FREQ_W-1:0] f);
         cmd_type c;
         c.kind  = k;
         c.phase = 2'(ph);
         c.drive = dv;
         c.duty  = du;
         c.freq  = f;
         c.last  = 1'b0;
         expected.push_back(c);
      endfunction

      function void all_phases_off();
         for (int ph = 0; ph < PHASES; ph++) add(CMD_SET_MODE, ph, DRV_OFF, duty_idle, '0);
      endfunction

      // Accepted input item: queue the commands it must cause
      function void note_item(item_type it);
         logic [DUTY_W-1:0] duty, d;
         drive_type         m;
         int                first;
         first = expected.size();
         case (it.mode)
            OP_STEP: if (it.step_index <= LAST_STEP) begin
               duty = clamp(it.duty_request);
               // new frequency invalidates every phase mode
               if (it.pwm_frequency != freq_now) begin
                  add(CMD_SET_FREQ, 0, DRV_OFF, '0, it.pwm_frequency);
                  freq_now = it.pwm_frequency;
                  for (int ph = 0; ph < PHASES; ph++) mode_now[ph] = DRV_UNKNOWN;
               end
               for (int ph = 0; ph < PHASES; ph++) begin
                  m = planned_drive(it.step_index, ph);
                  d = (m == DRV_HIGH) ? duty : (m == DRV_LOW) ? duty_floor : duty_idle;
                  if (m != mode_now[ph]) begin
                     add(CMD_SET_MODE, ph, m, d, '0);
                     mode_now[ph] = m;
                     duty_now[ph] = d;
                  end else if (m == DRV_HIGH && d != duty_now[ph]) begin
                     add(CMD_SET_DUTY, ph, DRV_HIGH, d, '0);
                     duty_now[ph] = d;
                  end
               end
            end
            OP_SET_DUTY: if (it.step_index <= LAST_STEP) begin
               duty = clamp(it.duty_request);
               for (int ph = 0; ph < PHASES; ph++) begin
                  if (planned_drive(it.step_index, ph) == DRV_HIGH) begin
                     add(CMD_SET_DUTY, ph, DRV_HIGH, duty, '0);
                     duty_now[ph] = duty;
                  end
               end
            end
            OP_STOP: all_phases_off();
            default: begin
               for (int ph = 0; ph < PHASES; ph++) mode_now[ph] = DRV_UNKNOWN;
               all_phases_off();
            end
         endcase
         if (expected.size() > first) expected[expected.size()-1].last = 1'b1;
      endfunction

      function void report(string what, cmd_type want, cmd_type got);
         errors++;
         if (errors <= 10)
            $display("%s: expected kind %0d phase %0d drive %0d duty %0d freq %0h last %0d,",
                     what, want.kind, want.phase, want.drive, want.duty, want.freq, want.last,
                     " got kind %0d phase %0d drive %0d duty %0d freq %0h last %0d",
                     got.kind, got.phase, got.drive, got.duty, got.freq, got.last);
      endfunction

      // Accepted command: compare with the oldest expectation
      function void check_cmd(cmd_type got);
         cmd_type want;
         if (expected.size() == 0) begin
            want = '0;
            report("unexpected command", want, got);
            return;
         end
         want = expected.pop_front();
         if (got.kind !== want.kind || got.phase !== want.phase ||
             got.drive !== want.drive || got.duty !== want.duty ||
             got.freq !== want.freq || got.last !== want.last)
            report("command mismatch", want, got);
      endfunction

      function void flush_leftover();
         cmd_type none;
         none = '0;
         while (expected.size() > 0) report("missing command", expected.pop_front(), none);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic [CSR_W-1:0]    csr_index;
   logic [DUTY_W-1:0]   csr_write_data;

   sscs_req_if req_ch ();
   sscs_rsp_if rsp_ch ();

   six_step_commutation_sequencer DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   commutation_scoreboard sb = new();

   int src_idle_pct = 0;
   int rcv_idle_pct = 0;
   int cycles = 0;

   // rotation state for well-formed commutation sequences
   int                rot_step = 0;
   bit                rot_back = 1'b0;
   logic [FREQ_W-1:0] cur_freq = 32'd20000;
   logic [DUTY_W-1:0] cur_duty = 14'd5000;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver stalls
   always @(negedge clock) rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      item_type it;
      cmd_type  got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.mode          = op_type'(req_ch.mode);
            it.step_index    = req_ch.step_index;
            it.pwm_frequency = req_ch.pwm_frequency;
            it.duty_request  = req_ch.duty_request;
            sb.note_item(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind  = kind_type'(rsp_ch.command_kind);
            got.phase = rsp_ch.phase;
            got.drive = drive_type'(rsp_ch.drive_mode);
            got.duty  = rsp_ch.duty_value;
            got.freq  = rsp_ch.frequency_value;
            got.last  = rsp_ch.last_command;
            sb.check_cmd(got);
         end
      end
   end

   // Enters and leaves at a falling edge; holds the item until accepted
   task automatic send_item(item_type it);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= it.mode;
      req_ch.step_index    <= it.step_index;
      req_ch.pwm_frequency <= it.pwm_frequency;
      req_ch.duty_request  <= it.duty_request;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_op(op_type op, int step, logic [FREQ_W-1:0] f, int duty);
      item_type it;
      it.mode          = op;
      it.step_index    = 3'(step);
      it.pwm_frequency = f;
      it.duty_request  = 14'(duty);
      send_item(it);
   endtask

   // Drain everything, then program the duty registers
   task automatic settle_and_write(int floor_v, int ceiling_v, int idle_v);
      csr_type           idx [3];
      logic [DUTY_W-1:0] val [3];
      idx = '{CSR_FLOOR, CSR_CEILING, CSR_IDLE};
      val = '{14'(floor_v), 14'(ceiling_v), 14'(idle_v)};
      req_ch.valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      for (int i = 0; i < 3; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_write_data   <= val[i];
         sb.write_reg(idx[i], val[i]);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Mostly rotating steps at a steady frequency, with occasional noise
   function automatic item_type make_item();
      item_type it;
      int       pick;
      pick = $urandom_range(99);
      if (pick < 62)      it.mode = OP_STEP;
      else if (pick < 78) it.mode = OP_SET_DUTY;
      else if (pick < 89) it.mode = OP_STOP;
      else                it.mode = OP_INIT;

      if ($urandom_range(19) == 0) begin
         it.step_index = 3'($urandom_range(7));
      end else begin
         if (it.mode == OP_STEP) begin
            if ($urandom_range(15) == 0) rot_back = ~rot_back;
            if (rot_back) rot_step = (rot_step == 0) ? 5 : rot_step - 1;
            else          rot_step = (rot_step == 5) ? 0 : rot_step + 1;
         end
         it.step_index = 3'(rot_step);
      end

      pick = $urandom_range(99);
      if (pick < 75)      it.pwm_frequency = cur_freq;
      else if (pick < 88) it.pwm_frequency = 32'(16000 + 4000 * $urandom_range(3));
      else if (pick < 96) it.pwm_frequency = $urandom;
      else                it.pwm_frequency = $urandom_range(1) ? '1 : '0;
      cur_freq = it.pwm_frequency;

      pick = $urandom_range(99);
      if (pick < 55)      it.duty_request = cur_duty;
      else if (pick < 78) it.duty_request = 14'($urandom_range(10000));
      else if (pick < 90) it.duty_request = 14'(cur_duty > 9900 ? 9900 : cur_duty + 100);
      else                it.duty_request = $urandom_range(1) ? 14'd10000 : 14'd0;
      cur_duty = it.duty_request;
      return it;
   endfunction

   task automatic run_random(int goal);
      item_type it;
      int       counted;
      counted = 0;
      while (counted < goal) begin
         it = make_item();
         send_item(it);
         // steps past five are ignored by the block
         if (it.mode == OP_STOP || it.mode == OP_INIT || it.step_index <= LAST_STEP)
            counted++;
      end
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.mode          = OP_STEP;
      req_ch.step_index    = '0;
      req_ch.pwm_frequency = '0;
      req_ch.duty_request  = '0;
      rsp_ch.ready         = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_FLOOR;
      csr_write_data       = '0;
      reset                = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: full reprogram, no change, duty-only, saturation, ignored steps
      send_op(OP_STEP,     0, 32'd20000,    5000);
      send_op(OP_STEP,     0, 32'd20000,    5000);
      send_op(OP_STEP,     0, 32'd20000,    6000);
      send_op(OP_STEP,     1, 32'd20000,    6000);
      send_op(OP_STEP,     2, 32'd20000,    0);
      send_op(OP_STEP,     3, 32'd20000,    10000);
      send_op(OP_SET_DUTY, 3, 32'd20000,    4000);
      send_op(OP_SET_DUTY, 6, 32'd20000,    4000);
      send_op(OP_STEP,     7, 32'd1,        3000);
      send_op(OP_STEP,     6, 32'd7,        3000);
      send_op(OP_STOP,     3, 32'd20000,    3000);
      send_op(OP_STEP,     3, 32'd20000,    4000);
      send_op(OP_INIT,     0, 32'd20000,    4000);
      send_op(OP_STEP,     4, 32'd0,        8191);
      send_op(OP_STEP,     5, 32'hFFFFFFFF, 8192);
      send_op(OP_SET_DUTY, 0, 32'd0,        9800);
      send_op(OP_SET_DUTY, 1, 32'd0,        200);
      send_op(OP_SET_DUTY, 2, 32'd0,        199);
      send_op(OP_SET_DUTY, 4, 32'd0,        9801);
      send_op(OP_SET_DUTY, 5, 32'd0,        1);
      send_op(OP_STEP,     5, 32'hAAAAAAAA, 5461);
      send_op(OP_STEP,     0, 32'h55555555, 10922);
      send_op(OP_STOP,     7, 32'd0,        0);
      send_op(OP_INIT,     6, 32'hFFFFFFFF, 10000);

      // Random: sender idles less than the receiver
      src_idle_pct = 30;
      rcv_idle_pct = 80;
      settle_and_write(0, 10000, 10000);
      run_random(SEGMENT_ITEMS);
      settle_and_write(7000, 3000, 123);
      run_random(SEGMENT_ITEMS);

      // Random: receiver idles less than the sender
      src_idle_pct = 80;
      rcv_idle_pct = 30;
      settle_and_write(10000, 10000, 0);
      run_random(SEGMENT_ITEMS);
      settle_and_write(0, 0, 10000);
      run_random(SEGMENT_ITEMS);

      // Random: full throughput
      src_idle_pct = 0;
      rcv_idle_pct = 0;
      settle_and_write(1500, 8500, 500);
      run_random(SEGMENT_ITEMS);
      settle_and_write(200, 9800, 0);
      run_random(SEGMENT_ITEMS);

      // Drain and wrap up
      req_ch.valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      sb.flush_leftover();
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
